// File: hdl/oal_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list package
// Field widths, word layout, operation and status codes shared by the list
// controller and its ports.
// ----------------------------------------------------------------------------
package oal_pkg;

   // Field widths of the request and response words.
   localparam int OP_W     = 2;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 11;

   // Default number of entries the list can hold.
   localparam int unsigned CAPACITY_DEF = 1024;

   // Packed word widths, rounded up to whole bytes.
   localparam int REQ_BITS = OP_W + POS_W + VALUE_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + VALUE_W + LEN_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// File: hdl/oal_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with output register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/ordered_array_list.sv
// ----------------------------------------------------------------------------
// Ordered array list
// Keeps an ordered list of signed 32-bit entries in a RAM plus a count and
// serves append, insert, delete and read requests, one word per request.
// ----------------------------------------------------------------------------
// Path to the response word: a rejected request or a delete of the last entry
// goes straight to S_DONE, an append or an insert at the end via S_PUT, a read
// via S_FETCH and S_LATCH, an insert via S_SHIFT, S_DRAIN and S_PUT, a delete
// via S_SHIFT and S_DRAIN (up to CAPACITY - 1 moves, one RAM word per cycle).
// One request at a time; the next one enters once the response is registered.
// Reset clears the count and the handshake state; the entry RAM is not cleared.
module ordered_array_list #(
   parameter int unsigned CAPACITY = oal_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // op [1:0], position [12:2], value [44:13], zero fill above
   input  logic [oal_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status [1:0], read_value [33:2], length [44:34], zero fill above
   output logic [oal_pkg::RSP_W-1:0] rsp_tdata
);

   import oal_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Sequencer states.
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SHIFT = 7'b0000010,
      S_DRAIN = 7'b0000100,
      S_PUT   = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_LATCH = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        end_ff, end_in;
   logic                 up_ff, up_in;
   logic                 ins_ff, ins_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic [AW-1:0]        put_addr_ff, put_addr_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   read_ff, read_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_read_ff, rsp_read_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   op_type               req_op;
   logic [POS_W-1:0]     req_pos;
   logic [VALUE_W-1:0]   req_value;
   logic                 accept;

   logic [CMPW-1:0]      cnt_ext, pos_ext, cap_ext, cnt_dec, pos_inc;
   logic                 full, pos_gt, pos_ge, pos_last;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr;
   logic [VALUE_W-1:0]   ram_wdata, ram_rdata;

   // Unpack the request word.
   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_pos   = req_tdata[OP_W +: POS_W];
   assign req_value = req_tdata[OP_W + POS_W +: VALUE_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Position checks against the current count.
   assign cnt_ext  = CMPW'(count_ff);
   assign pos_ext  = CMPW'(req_pos);
   assign cap_ext  = CMPW'(CAPACITY);
   assign cnt_dec  = cnt_ext - CMPW'(1);
   assign pos_inc  = pos_ext + CMPW'(1);
   assign full     = (cnt_ext == cap_ext);
   assign pos_gt   = (pos_ext > cnt_ext);
   assign pos_ge   = (pos_ext >= cnt_ext);
   assign pos_last = (pos_ext == cnt_dec);

   // RAM ports: moves during shifting, the new entry in the put step.
   assign ram_re    = (state_ff == S_SHIFT) || (state_ff == S_FETCH);
   assign ram_we    = (pend_ff && ((state_ff == S_SHIFT) || (state_ff == S_DRAIN))) ||
                      (state_ff == S_PUT);
   assign ram_waddr = (state_ff == S_PUT) ? put_addr_ff : pend_addr_ff;
   assign ram_wdata = (state_ff == S_PUT) ? value_ff : ram_rdata;

   oal_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      up_in         = up_ff;
      ins_in        = ins_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      put_addr_in   = put_addr_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      read_in       = read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_len_in    = rsp_len_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               status_in = ST_DONE;
               read_in   = '0;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        put_addr_in = cnt_ext[AW-1:0];
                        state_in    = S_PUT;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_gt) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else if (pos_ge) begin
                        // Insert at the end is an append.
                        put_addr_in = pos_ext[AW-1:0];
                        state_in    = S_PUT;
                     end else begin
                        // Move entries up, from the last one down to the position.
                        idx_in      = cnt_dec[AW-1:0];
                        end_in      = pos_ext[AW-1:0];
                        up_in       = 1'b0;
                        ins_in      = 1'b1;
                        put_addr_in = pos_ext[AW-1:0];
                        state_in    = S_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_ge) begin
                        status_in = ST_RANGE;
                     end else if (pos_last) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        // Move entries down, from above the position to the last one.
                        idx_in   = pos_inc[AW-1:0];
                        end_in   = cnt_dec[AW-1:0];
                        up_in    = 1'b1;
                        ins_in   = 1'b0;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_READ: begin
                     if (pos_ge) begin
                        status_in = ST_RANGE;
                     end else begin
                        idx_in   = pos_ext[AW-1:0];
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end

         // Read one entry per cycle; the word read last cycle is written one slot over.
         S_SHIFT: begin
            pend_in      = 1'b1;
            pend_addr_in = up_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            if (idx_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = up_ff ? (idx_ff + AW'(1)) : (idx_ff - AW'(1));
            end
         end

         // Write the last moved word.
         S_DRAIN: begin
            pend_in = 1'b0;
            if (ins_ff) begin
               state_in = S_PUT;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         // Store the new entry.
         S_PUT: begin
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end

         S_FETCH: begin
            state_in = S_LATCH;
         end

         S_LATCH: begin
            read_in  = ram_rdata;
            state_in = S_DONE;
         end

         // Hand the result to the response register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_read_in   = read_ff;
               rsp_len_in    = cnt_ext[LEN_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      up_ff         <= up_in;
      ins_ff        <= ins_in;
      pend_addr_ff  <= pend_addr_in;
      put_addr_ff   <= put_addr_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      read_ff       <= read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // Pack the response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_len_ff, rsp_read_ff, rsp_status_ff});

   // The count never goes past the capacity.
   assert property (@(posedge clock) disable iff (reset) cnt_ext <= cap_ext)
      else $error("list count exceeds capacity");

   // The RAM is never written while the sequencer waits for a request.
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_IDLE) |-> !ram_we)
      else $error("RAM write while idle");

   // The count moves by one at most per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CW'(1)) || (count_ff == $past(count_ff) - CW'(1))))
      else $error("list count jumped by more than one");

endmodule
